@@ sv/nfci_pkg.sv @@
// ----------------------------------------------------------------------------
// nfci_pkg
// types, constants and command codes shared by the nand bus device model
// ----------------------------------------------------------------------------
package nfci_pkg;

  localparam int PageBytes     = 2112;
  localparam int PagesPerBlock = 64;
  localparam int NumBlocks     = 4;
  localparam int TotalPages    = PagesPerBlock * NumBlocks;
  localparam int ColW          = $clog2(PageBytes + 1);
  localparam int PageW         = $clog2(TotalPages);
  localparam int BlkW          = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
  localparam int PgInBlkW      = (PagesPerBlock > 1) ? $clog2(PagesPerBlock) : 1;
  localparam int ArrW          = $clog2(TotalPages * PageBytes);
  localparam int BufW          = $clog2(PageBytes);
  localparam int CfgIdxW       = 2;

  localparam logic [7:0] CMD_READ      = 8'h00;
  localparam logic [7:0] CMD_RAND_OUT  = 8'h05;
  localparam logic [7:0] CMD_PROG_CONF = 8'h10;
  localparam logic [7:0] CMD_READ_CONF = 8'h30;
  localparam logic [7:0] CMD_ERASE     = 8'h60;
  localparam logic [7:0] CMD_STATUS    = 8'h70;
  localparam logic [7:0] CMD_PROG      = 8'h80;
  localparam logic [7:0] CMD_ERASE_CNF = 8'hD0;
  localparam logic [7:0] CMD_RAND_CONF = 8'hE0;
  localparam logic [7:0] CMD_RESET     = 8'hFF;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_POLL  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_READ_TICKS  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PROG_TICKS  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ERASE_TICKS = 2'd2;

  localparam logic [7:0] STATUS_BUSY_BIT = 8'h40;

  typedef struct packed {
    logic [1:0] opcode;
    logic       cle;
    logic       ale;
    logic [7:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       busy_res;
  } out_word_t;

  typedef enum logic [2:0] {
    COPY_NONE  = 3'b001,
    COPY_LOAD  = 3'b010,
    COPY_PROG  = 3'b100
  } copy_kind_t;

  // controller -> datapath
  typedef struct packed {
    logic       start;
    copy_kind_t kind;
    logic [PageW-1:0] page;
    logic       erase;
    logic [BlkW-1:0] block;
  } copy_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;
  } copy_sts_t;

endpackage

@@ sv/nand_flash_command_interface_top.sv @@
// ----------------------------------------------------------------------------
// nand_flash_command_interface_top
// large-page 8-bit nand device model at its bus, one result word per bus word
// ----------------------------------------------------------------------------
//  channel | signals                      | word
//  in      | in_valid  in_stall  in_data  | opcode cle ale data_in
//  out     | out_valid out_stall out_data | data_out busy_res
//  cfg     | cfg_we cfg_idx cfg_wdata     | busy tick counts
// a plain word is taken in the idle state; a data read goes through C_RDB and
// C_OUT (page buffer read port); a page read or program confirm copies the page
// through the array port, each byte in S_RD then S_WR; erase clears marks only
// reset is synchronous; the array is erased through per-page marks, no sweep
// an output word waiting under stall holds the next input word off
module nand_flash_command_interface_top import nfci_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [7:0] cfg_wdata
);

  copy_cmd_t cmd;
  copy_sts_t sts;
  logic buf_we, buf_re;
  logic [BufW-1:0] buf_waddr, buf_raddr;
  logic [7:0] buf_wdata, buf_rdata;

  nfci_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_idx, .cfg_wdata, .cmd, .sts, .buf_we, .buf_waddr, .buf_wdata,
    .buf_re, .buf_raddr, .buf_rdata
  );

  nfci_datapath u_dp (
    .clk, .rst, .cmd, .sts, .buf_we, .buf_waddr, .buf_wdata,
    .buf_re, .buf_raddr, .buf_rdata
  );

  a_stall_on_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall) else $error("input taken over held word");

  a_busy_field: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.busy_res) |-> (out_data.data_out == 8'd0))
    else $error("busy and data both set");

  a_start_in_copy: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> in_stall) else $error("input open during copy");

endmodule

@@ sv/nfci_datapath.sv @@
// ----------------------------------------------------------------------------
// nfci_datapath
// flash array, page buffer, erase marks; copies alternate S_RD, S_WR each cycle
// ----------------------------------------------------------------------------
module nfci_datapath import nfci_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  copy_cmd_t       cmd,
  output copy_sts_t       sts,
  input  logic            buf_we,
  input  logic [BufW-1:0] buf_waddr,
  input  logic [7:0]      buf_wdata,
  input  logic            buf_re,
  input  logic [BufW-1:0] buf_raddr,
  output logic [7:0]      buf_rdata
);

  logic [7:0] flash [TotalPages*PageBytes];
  logic [7:0] pbuf [PageBytes];
  // page written since its block was last erased
  logic [TotalPages-1:0] page_prog;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_WR   = 4'b0100,
    S_DONE = 4'b1000
  } dp_state_t;

  dp_state_t state;
  copy_kind_t kind;
  logic [PageW-1:0] page;
  logic [ColW-1:0] idx;
  logic [BufW-1:0] idx_d;
  logic pg_valid;
  logic [7:0] fl_q;
  logic [7:0] pb_q;
  logic [ArrW-1:0] base;

  assign base = ArrW'(page) * ArrW'(PageBytes);
  assign sts.done = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      page_prog <= '0;
      idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.start) begin
            if (cmd.erase) begin
              for (int p = 0; p < PagesPerBlock; p++) begin
                page_prog[{cmd.block, PgInBlkW'(p)}] <= 1'b0;
              end
              state <= S_DONE;
            end else begin
              kind <= cmd.kind;
              page <= cmd.page;
              pg_valid <= page_prog[cmd.page];
              idx <= '0;
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          idx_d <= idx[BufW-1:0];
          idx <= idx + ColW'(1);
          state <= S_WR;
        end
        S_WR: begin
          if (idx == ColW'(PageBytes)) begin
            if (kind == COPY_PROG) page_prog[page] <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_RD;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    fl_q <= flash[base + ArrW'(idx[BufW-1:0])];
    if (state == S_WR && kind == COPY_PROG) begin
      flash[base + ArrW'(idx_d)] <= pb_q;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RD) begin
      pb_q <= pbuf[idx[BufW-1:0]];
    end else if (buf_re) begin
      buf_rdata <= pbuf[buf_raddr];
    end
    if (state == S_WR && kind == COPY_LOAD) begin
      pbuf[idx_d] <= pg_valid ? fl_q : 8'hFF;
    end else if (buf_we) begin
      pbuf[buf_waddr] <= buf_wdata;
    end
  end

endmodule

@@ sv/nfci_ctrl.sv @@
// ----------------------------------------------------------------------------
// nfci_ctrl
// bus cycle decoder, address latch, pointers, busy countdown and handshakes
// ----------------------------------------------------------------------------
module nfci_ctrl import nfci_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_word_t        in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output out_word_t       out_data,
  input  logic            cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [7:0]      cfg_wdata,
  output copy_cmd_t       cmd,
  input  copy_sts_t       sts,
  output logic            buf_we,
  output logic [BufW-1:0] buf_waddr,
  output logic [7:0]      buf_wdata,
  output logic            buf_re,
  output logic [BufW-1:0] buf_raddr,
  input  logic [7:0]      buf_rdata
);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_COPY = 4'b0010,
    C_RDB  = 4'b0100,
    C_OUT  = 4'b1000
  } ctl_state_t;

  ctl_state_t state;
  logic [7:0] rd_ticks, pg_ticks, er_ticks;
  logic [7:0] addr [5];
  logic [2:0] slot, remaining;
  logic [7:0] pending;
  logic [ColW-1:0] rptr, wptr;
  logic rvalid, wvalid;
  logic [7:0] busy;
  logic status_mode, armed;
  logic ob_valid;
  out_word_t ob;

  logic [15:0] col;
  logic [23:0] row;
  logic in_rng;
  logic acc;
  logic ready_cmd;

  assign col = {addr[1], addr[0]};
  assign row = {addr[4], addr[3], addr[2]};
  assign in_rng = row < 24'(TotalPages);
  assign acc = in_valid && !in_stall;
  assign in_stall = (state != C_IDLE) || (ob_valid && out_stall);
  assign out_valid = ob_valid;
  assign out_data = ob;
  assign ready_cmd = (busy == 8'd0);

  assign buf_wdata = in_data.data_in;
  assign buf_waddr = wptr[BufW-1:0];
  assign buf_we = acc && in_data.opcode == OP_WRITE && !in_data.cle && !in_data.ale &&
                  wvalid && wptr < ColW'(PageBytes);
  assign buf_raddr = rptr[BufW-1:0];
  assign buf_re = acc && in_data.opcode == OP_READ && !in_data.cle && !in_data.ale &&
                  !status_mode && busy == 8'd0 && rvalid && rptr < ColW'(PageBytes);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ticks <= 8'd2;
      pg_ticks <= 8'd2;
      er_ticks <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_READ_TICKS:  rd_ticks <= cfg_wdata;
        CFG_PROG_TICKS:  pg_ticks <= cfg_wdata;
        CFG_ERASE_TICKS: er_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      for (int i = 0; i < 5; i++) addr[i] <= 8'd0;
      slot <= 3'd0;
      remaining <= 3'd0;
      pending <= CMD_RESET;
      rptr <= '0;
      wptr <= '0;
      rvalid <= 1'b0;
      wvalid <= 1'b0;
      busy <= 8'd0;
      status_mode <= 1'b0;
      armed <= 1'b0;
      ob_valid <= 1'b0;
      cmd.start <= 1'b0;
      cmd.kind <= COPY_NONE;
      cmd.page <= '0;
      cmd.erase <= 1'b0;
      cmd.block <= '0;
    end else begin
      cmd.start <= 1'b0;
      if (ob_valid && !out_stall) ob_valid <= 1'b0;
      case (state)
        C_IDLE: begin
          if (acc) begin
            ob.data_out <= 8'd0;
            ob.busy_res <= 1'b0;
            ob_valid <= 1'b1;
            case (in_data.opcode)
              OP_WRITE: begin
                if (in_data.cle && !in_data.ale) begin
                  case (in_data.data_in)
                    CMD_READ: begin
                      if (ready_cmd) status_mode <= 1'b0;
                      slot <= 3'd0; remaining <= 3'd5; pending <= CMD_READ;
                      armed <= 1'b1;
                    end
                    CMD_RAND_OUT: begin
                      if (ready_cmd) status_mode <= 1'b0;
                      slot <= 3'd0; remaining <= 3'd2; pending <= CMD_RAND_OUT;
                    end
                    CMD_PROG_CONF: begin
                      if (ready_cmd) status_mode <= 1'b0;
                      busy <= pg_ticks;
                      pending <= CMD_RESET;
                      if (in_rng) begin
                        cmd.start <= 1'b1; cmd.erase <= 1'b0;
                        cmd.kind <= COPY_PROG; cmd.page <= row[PageW-1:0];
                        state <= C_COPY;
                      end
                    end
                    CMD_READ_CONF: begin
                      if (ready_cmd) status_mode <= 1'b0;
                      pending <= CMD_RESET;
                      if (armed) begin
                        armed <= 1'b0;
                        busy <= rd_ticks;
                        if (in_rng) begin
                          cmd.start <= 1'b1; cmd.erase <= 1'b0;
                          cmd.kind <= COPY_LOAD; cmd.page <= row[PageW-1:0];
                          state <= C_COPY;
                        end
                      end
                    end
                    CMD_ERASE: begin
                      if (ready_cmd) status_mode <= 1'b0;
                      slot <= 3'd2; remaining <= 3'd3; pending <= CMD_ERASE;
                    end
                    CMD_STATUS: status_mode <= 1'b1;
                    CMD_PROG: begin
                      if (ready_cmd) status_mode <= 1'b0;
                      slot <= 3'd0; remaining <= 3'd5; pending <= CMD_PROG;
                    end
                    CMD_ERASE_CNF: begin
                      if (ready_cmd) status_mode <= 1'b0;
                      busy <= er_ticks;
                      pending <= CMD_RESET;
                      if (in_rng) begin
                        cmd.start <= 1'b1; cmd.erase <= 1'b1;
                        cmd.kind <= COPY_NONE;
                        cmd.block <= BlkW'(row[PageW-1:0] / PageW'(PagesPerBlock));
                        state <= C_COPY;
                      end
                    end
                    CMD_RESET: begin
                      rvalid <= 1'b0; wvalid <= 1'b0;
                      slot <= 3'd0; remaining <= 3'd0;
                      pending <= CMD_RESET; busy <= 8'd0;
                      status_mode <= 1'b0; armed <= 1'b0;
                    end
                    default: ;
                  endcase
                end else if (in_data.ale && !in_data.cle) begin
                  if (remaining != 3'd0 && slot <= 3'd4) begin
                    addr[slot] <= in_data.data_in;
                    slot <= slot + 3'd1;
                    remaining <= remaining - 3'd1;
                    if (remaining == 3'd1) begin
                      rvalid <= 1'b0;
                      wvalid <= 1'b0;
                      if (slot == 3'd1) begin
                        if (pending == CMD_PROG) begin
                          wptr <= ColW'(({in_data.data_in, addr[0]} > 16'(PageBytes)) ?
                                  16'(PageBytes) : {in_data.data_in, addr[0]});
                          wvalid <= 1'b1;
                        end else if (pending == CMD_READ || pending == CMD_RAND_OUT) begin
                          rptr <= ColW'(({in_data.data_in, addr[0]} > 16'(PageBytes)) ?
                                  16'(PageBytes) : {in_data.data_in, addr[0]});
                          rvalid <= 1'b1;
                        end
                      end else begin
                        if (pending == CMD_PROG) begin
                          wptr <= ColW'((col > 16'(PageBytes)) ? 16'(PageBytes) : col);
                          wvalid <= 1'b1;
                        end else if (pending == CMD_READ || pending == CMD_RAND_OUT) begin
                          rptr <= ColW'((col > 16'(PageBytes)) ? 16'(PageBytes) : col);
                          rvalid <= 1'b1;
                        end
                      end
                    end
                  end
                end else if (!in_data.ale && !in_data.cle) begin
                  if (buf_we) wptr <= wptr + ColW'(1);
                end
              end
              OP_READ: begin
                if (!in_data.cle && !in_data.ale) begin
                  if (status_mode) begin
                    if (busy != 8'd0) begin
                      busy <= busy - 8'd1;
                      ob.data_out <= 8'hFF & ~STATUS_BUSY_BIT;
                    end else begin
                      ob.data_out <= 8'hFF;
                    end
                  end else if (buf_re) begin
                    rptr <= rptr + ColW'(1);
                    ob_valid <= 1'b0;
                    state <= C_RDB;
                  end
                end
              end
              OP_POLL: begin
                if (busy != 8'd0) begin
                  busy <= busy - 8'd1;
                  ob.busy_res <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        C_COPY: if (sts.done) state <= C_IDLE;
        C_RDB: state <= C_OUT;
        C_OUT: begin
          ob.data_out <= buf_rdata;
          ob_valid <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

@@ test/nand_flash_command_interface_checker.sv @@
// ----------------------------------------------------------------------------
// nand_flash_command_interface_checker
// watches the bus and config ports of the nand device, keeps its own copy of
// the device state, predicts each result word and compares it field by field
// ----------------------------------------------------------------------------
module nand_flash_command_interface_checker import nfci_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  in_word_t           in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  out_word_t          out_data,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [7:0]         cfg_wdata,
  output int                 errors,
  output int                 waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  bit [7:0]  flash_mem [TotalPages*PageBytes];
  bit [7:0]  page_buf [PageBytes];
  bit [7:0]  addr_reg [5];
  int        addr_slot, addr_left;
  int        rd_ptr, wr_ptr;
  bit        rd_ok, wr_ok;
  bit [7:0]  pend_cmd, busy_cnt;
  bit        status_on, read_armed;
  bit [7:0]  tick_set [3];
  out_word_t expected_words [$];

  function automatic void go_idle();
    rd_ok = 0;
    wr_ok = 0;
    addr_slot = 0;
    addr_left = 0;
    pend_cmd = CMD_RESET;
    busy_cnt = 0;
    status_on = 0;
    read_armed = 0;
  endfunction

  function automatic void leave_status();
    if (busy_cnt == 0) status_on = 0;
  endfunction

  function automatic void latch_address(bit [7:0] b);
    int col;
    if (addr_left == 0 || addr_slot > 4) return;
    addr_reg[addr_slot] = b;
    addr_slot++;
    addr_left--;
    if (addr_left == 0) begin
      col = int'({addr_reg[1], addr_reg[0]});
      rd_ok = 0;
      wr_ok = 0;
      if (pend_cmd == CMD_PROG) begin
        wr_ptr = col;
        wr_ok = 1;
      end else if (pend_cmd == CMD_READ || pend_cmd == CMD_RAND_OUT) begin
        rd_ptr = col;
        rd_ok = 1;
      end
    end
  endfunction

  function automatic void latch_command(bit [7:0] b);
    int row, base;
    bit ok;
    row = int'({addr_reg[4], addr_reg[3], addr_reg[2]});
    ok = row < TotalPages;
    case (b)
      CMD_READ: begin
        leave_status();
        addr_slot = 0; addr_left = 5; pend_cmd = CMD_READ;
        read_armed = 1;
      end
      CMD_RAND_OUT: begin
        leave_status();
        addr_slot = 0; addr_left = 2; pend_cmd = CMD_RAND_OUT;
      end
      CMD_PROG_CONF: begin
        leave_status();
        if (ok) for (int i = 0; i < PageBytes; i++) flash_mem[row*PageBytes+i] = page_buf[i];
        busy_cnt = tick_set[CFG_PROG_TICKS];
        pend_cmd = CMD_RESET;
      end
      CMD_READ_CONF: begin
        leave_status();
        if (read_armed) begin
          read_armed = 0;
          if (ok) for (int i = 0; i < PageBytes; i++) page_buf[i] = flash_mem[row*PageBytes+i];
          busy_cnt = tick_set[CFG_READ_TICKS];
        end
        pend_cmd = CMD_RESET;
      end
      CMD_ERASE: begin
        leave_status();
        addr_slot = 2; addr_left = 3; pend_cmd = CMD_ERASE;
      end
      CMD_STATUS: status_on = 1;
      CMD_PROG: begin
        leave_status();
        addr_slot = 0; addr_left = 5; pend_cmd = CMD_PROG;
      end
      CMD_ERASE_CNF: begin
        leave_status();
        busy_cnt = tick_set[CFG_ERASE_TICKS];
        if (ok) begin
          base = (row / PagesPerBlock) * PagesPerBlock * PageBytes;
          for (int i = 0; i < PagesPerBlock*PageBytes; i++) flash_mem[base+i] = 8'hFF;
        end
        pend_cmd = CMD_RESET;
      end
      CMD_RESET: go_idle();
      default: ;
    endcase
  endfunction

  function automatic bit [7:0] read_byte();
    bit [7:0] s;
    if (status_on) begin
      s = 8'hFF;
      if (busy_cnt > 0) begin
        busy_cnt--;
        s &= ~STATUS_BUSY_BIT;
      end
      return s;
    end
    if (busy_cnt > 0 || !rd_ok || rd_ptr >= PageBytes) return 8'h00;
    s = page_buf[rd_ptr];
    rd_ptr++;
    return s;
  endfunction

  function automatic out_word_t bus_cycle(in_word_t w);
    out_word_t r;
    r = '0;
    case (w.opcode)
      OP_WRITE: begin
        if (w.cle && w.ale) ;
        else if (w.cle) latch_command(w.data_in);
        else if (w.ale) latch_address(w.data_in);
        else if (wr_ok && wr_ptr < PageBytes) begin
          page_buf[wr_ptr] = w.data_in;
          wr_ptr++;
        end
      end
      OP_READ: if (!w.cle && !w.ale) r.data_out = read_byte();
      OP_POLL: if (busy_cnt > 0) begin
        busy_cnt--;
        r.busy_res = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    foreach (flash_mem[i]) flash_mem[i] = 8'hFF;
    errors = 0;
    waiting = 0;
  end

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst) begin
      foreach (addr_reg[i]) addr_reg[i] = 8'd0;
      rd_ptr = 0;
      wr_ptr = 0;
      go_idle();
      tick_set[CFG_READ_TICKS] = 8'd2;
      tick_set[CFG_PROG_TICKS] = 8'd2;
      tick_set[CFG_ERASE_TICKS] = 8'd5;
      expected_words.delete();
    end else begin
      if (cfg_we && cfg_idx <= CFG_ERASE_TICKS) tick_set[cfg_idx] = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result word: data_out %h busy_res %b",
                     out_data.data_out, out_data.busy_res);
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w.data_out !== out_data.data_out || exp_w.busy_res !== out_data.busy_res) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected data_out %h busy_res %b, got %h %b",
                       exp_w.data_out, exp_w.busy_res, out_data.data_out, out_data.busy_res);
          end
        end
      end
      if (in_valid && !in_stall) expected_words.push_back(bus_cycle(in_data));
    end
    waiting = expected_words.size();
  end
endmodule

@@ test/nand_flash_command_interface_top_tb.sv @@
// ----------------------------------------------------------------------------
// nand_flash_command_interface_top_tb
// drives bus words and tick settings into the nand device: a directed opening,
// then random command sequences with noise, stalls and a long output hold-off
// ----------------------------------------------------------------------------
module nand_flash_command_interface_top_tb;
  import nfci_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_NONE     = 2'd3;
  localparam logic [7:0] CMD_UNKNOWN = 8'h90;
  localparam int         SettleCycles = 2 * PageBytes + 200;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  logic      cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [7:0] cfg_wdata = '0;
  int        errors, waiting;
  int        sent = 0;
  bit        steady = 0;
  bit        hold_req = 0;
  bit [7:0]  tick_set [3] = '{8'd2, 8'd2, 8'd5};

  always #4 clk = ~clk;

  nand_flash_command_interface_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  nand_flash_command_interface_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .errors(errors), .waiting(waiting)
  );

  // output side stalls, with the long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
      end
      out_stall <= !steady && $urandom_range(99) < 38;
    end
  end

  task automatic send(logic [1:0] op, logic c, logic a, logic [7:0] b);
    while (!steady && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{opcode: op, cle: c, ale: a, data_in: b};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic cmd(logic [7:0] b);  send(OP_WRITE, 1'b1, 1'b0, b); endtask
  task automatic addr(logic [7:0] b); send(OP_WRITE, 1'b0, 1'b1, b); endtask
  task automatic data(logic [7:0] b); send(OP_WRITE, 1'b0, 1'b0, b); endtask
  task automatic rd();                send(OP_READ, 1'b0, 1'b0, 8'($urandom)); endtask
  task automatic poll();              send(OP_POLL, 1'b0, 1'b0, 8'($urandom)); endtask

  task automatic polls(int n);
    repeat ((n > 10 ? 10 : n) + $urandom_range(1)) poll();
  endtask

  task automatic page_addr(int col, int row);
    addr(col[7:0]); addr(col[15:8]);
    addr(row[7:0]); addr(row[15:8]); addr(row[23:16]);
  endtask

  function automatic int pick_col();
    int k;
    k = $urandom_range(9);
    if (k < 6) return $urandom_range(40);
    if (k < 9) return $urandom_range(PageBytes - 1, PageBytes - 12);
    return $urandom_range(16'hFFFF);
  endfunction

  function automatic int pick_row();
    if ($urandom_range(9) < 8) return $urandom_range(TotalPages - 1);
    return $urandom_range(24'hFFFFFF);
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    wait (waiting == 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic set_ticks(bit [7:0] r, bit [7:0] p, bit [7:0] e);
    drain();
    tick_set = '{r, p, e};
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= i[CfgIdxW-1:0];
      cfg_wdata <= tick_set[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_words(int n);
    int target;
    target = sent + n;
    while (sent < target) begin
      case ($urandom_range(9))
        0, 1: begin
          cmd(CMD_READ); page_addr(pick_col(), pick_row()); cmd(CMD_READ_CONF);
          polls(int'(tick_set[CFG_READ_TICKS]));
          repeat ($urandom_range(6)) rd();
        end
        2: begin
          cmd(CMD_PROG); page_addr(pick_col(), pick_row());
          repeat ($urandom_range(8)) data(8'($urandom));
          cmd(CMD_PROG_CONF);
          polls(int'(tick_set[CFG_PROG_TICKS]));
        end
        3: begin
          cmd(CMD_RAND_OUT);
          addr(8'($urandom_range(60))); addr($urandom_range(9) == 0 ? 8'($urandom) : 8'd0);
          cmd(CMD_RAND_CONF);
          repeat ($urandom_range(1, 5)) rd();
        end
        4: begin
          cmd(CMD_ERASE);
          addr(8'(pick_row())); addr(8'($urandom_range(7) == 0)); addr(8'd0);
          cmd(CMD_ERASE_CNF);
          polls(int'(tick_set[CFG_ERASE_TICKS]));
        end
        5: begin
          cmd(CMD_STATUS);
          repeat ($urandom_range(1, 4)) rd();
        end
        6: cmd(CMD_RESET);
        7: begin
          case ($urandom_range(3))
            0: cmd(CMD_READ);
            1: cmd(CMD_PROG);
            2: cmd(CMD_ERASE);
            default: cmd(CMD_RAND_OUT);
          endcase
          repeat ($urandom_range(3)) addr(8'($urandom));
          send(2'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
        end
        default:
          repeat ($urandom_range(1, 4))
            send(2'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
      endcase
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fill the page buffer first so that no later read hits an unwritten byte
    cmd(CMD_RESET);
    cmd(CMD_READ); page_addr(0, 0); cmd(CMD_READ_CONF);
    cmd(CMD_STATUS); rd(); rd(); rd();
    cmd(CMD_READ); page_addr(PageBytes - 1, TotalPages - 1); cmd(CMD_READ_CONF);
    poll(); poll(); poll(); rd(); rd();
    cmd(CMD_PROG); page_addr(0, 1); data(8'h00); data(8'hFF); data(8'hA5);
    cmd(CMD_PROG_CONF); poll(); poll();
    cmd(CMD_READ); page_addr(0, 1); cmd(CMD_READ_CONF); poll(); poll(); rd(); rd();
    cmd(CMD_RAND_OUT); addr(8'd2); addr(8'd0); cmd(CMD_RAND_CONF); rd();
    cmd(CMD_ERASE); addr(8'd1); addr(8'd0); addr(8'd0); cmd(CMD_ERASE_CNF);
    cmd(CMD_STATUS); repeat (6) rd();
    cmd(CMD_PROG_CONF); cmd(CMD_ERASE_CNF);
    cmd(CMD_READ); page_addr(16'hFFFF, 24'hFFFFFF); cmd(CMD_READ_CONF); poll(); poll(); rd();
    addr(8'h12); cmd(CMD_UNKNOWN);
    send(OP_NONE, 1'b1, 1'b1, 8'hFF); send(OP_WRITE, 1'b1, 1'b1, 8'h00);
    send(OP_READ, 1'b1, 1'b1, 8'h00);
    send(OP_READ, 1'b1, 1'b0, 8'h00); send(OP_READ, 1'b0, 1'b1, 8'h00);

    set_ticks(8'd0, 8'd0, 8'd0);
    random_words(180);
    set_ticks(8'd255, 8'd255, 8'd255);
    random_words(60);
    set_ticks(8'($urandom), 8'($urandom), 8'($urandom));
    steady = 1;
    random_words(80);
    steady = 0;
    hold_req = 1;
    random_words(100);
    drain();
    set_ticks(8'($urandom_range(6)), 8'($urandom_range(6)), 8'($urandom_range(6)));
    random_words(140);

    drain();
    if (errors == 0)
      $display("nand_flash_command_interface_top_tb: done, clean");
    else
      $display("nand_flash_command_interface_top_tb: done, errors");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("nand_flash_command_interface_top_tb: done, errors");
    $finish;
  end
endmodule

@@ files.f @@
sv/nfci_pkg.sv
sv/nfci_datapath.sv
sv/nfci_ctrl.sv
sv/nand_flash_command_interface_top.sv
test/nand_flash_command_interface_checker.sv
test/nand_flash_command_interface_top_tb.sv
